// File: rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is high
`define CRT_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds across reset
`define CRT_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/crt_pkg.sv
// ----------------------------------------------------------------------------
// crt_pkg
// Types and constants of the chunk reception tracker: field widths, request
// and status codes, register indexes and the control state type.
// ----------------------------------------------------------------------------
package crt_pkg;

   // field widths
   localparam int TYPE_W      = 2;
   localparam int IMG_W       = 3;
   localparam int IDX_W       = 16;
   localparam int LEN_W       = 16;
   localparam int STATUS_W    = 3;
   localparam int BYTE_W      = 24;
   localparam int CNT_W       = 11;
   localparam int SIZE_W      = 24;
   localparam int CHUNK_W     = 16;
   localparam int ICOUNT_W    = 3;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;
   localparam int NUM_SIZES   = 4;

   // request payload layout, lowest bit first
   localparam int REQ_IMG_LSB   = 0;
   localparam int REQ_IDX_LSB   = REQ_IMG_LSB + IMG_W;
   localparam int REQ_LEN_LSB   = REQ_IDX_LSB + IDX_W;
   localparam int REQ_TDATA_W   = ((REQ_LEN_LSB + LEN_W + 7) / 8) * 8;

   // response payload layout, lowest bit first
   localparam int RSP_NEW_BIT   = 0;
   localparam int RSP_SEEN_BIT  = 1;
   localparam int RSP_BYTES_LSB = 2;
   localparam int RSP_RCVD_LSB  = RSP_BYTES_LSB + BYTE_W;
   localparam int RSP_TOTAL_LSB = RSP_RCVD_LSB + CNT_W;
   localparam int RSP_CMPL_BIT  = RSP_TOTAL_LSB + CNT_W;
   localparam int RSP_USED_W    = RSP_CMPL_BIT + 1;
   localparam int RSP_TDATA_W   = ((RSP_USED_W + 7) / 8) * 8;

   // request kinds
   localparam logic [TYPE_W-1:0] REQ_ARRIVAL = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_QUERY   = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_CLEAR   = 2'd2;
   localparam logic [TYPE_W-1:0] REQ_UNUSED  = 2'd3;

   // response status codes
   localparam logic [STATUS_W-1:0] STATUS_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD_IMAGE = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_INDEX = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_BAD_LEN   = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_INVALID   = 3'd4;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_CHUNK_SIZE   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_COUNT  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_SIZE_0 = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_SIZE_3 = 3'd5;

   // control sequencer states
   typedef enum logic [2:0] {
      ST_INIT,        // bitmap clearing pass after reset
      ST_IDLE,        // waiting for a request
      ST_EXEC,        // bitmap word read back, check and write
      ST_CLR_SWEEP,   // bitmap clearing pass of a clear request
      ST_DIV_LOAD,    // start the chunk total of the next image
      ST_DIV_RUN,     // one quotient bit per cycle
      ST_DIV_CHECK,   // round up and range check one total
      ST_CLR_RESP     // report the outcome of a clear
   } crt_state_type;

endpackage

// File: rtl/crt_ram.sv
// ----------------------------------------------------------------------------
// crt_ram
// Generic single-clock RAM, one write port and one read port, read data
// registered.
// ----------------------------------------------------------------------------
module crt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // storage write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/chunk_reception_tracker.sv
// ----------------------------------------------------------------------------
// chunk_reception_tracker
// Keeps a per-image bitmap of received chunks with byte and chunk counters,
// checks each arriving chunk and answers bit queries and session clears.
// ----------------------------------------------------------------------------
// Usage
//   req_*  : one request per transaction (arrival, query, clear), kind in tuser
//   rsp_*  : exactly one response per request, status in tuser
//   csr_*  : register writes, always ready, written by user only while block idles, not enforced
// Arrivals, queries and unused kinds: the bitmap word is read at acceptance,
//   checked and, for a new chunk, written back in ST_EXEC together with the
//   response register load, which waits while the response is stalled. A new
//   request waits for that read-modify-write through the registered read port.
// Clear: a sweep zeroes all MAX_IMAGES*ceil(MAX_CHUNKS/32) bitmap words, then
//   a bit-serial divider (24 steps) works out the chunk total of each image,
//   then the response; req_tready stays low the whole time.
// Reset: the same bitmap clearing pass runs first with req_tready low; the
//   session is invalid until a clear request succeeds.
// Stall: a response held by rsp_tready low keeps its register; one more
//   request may be accepted meanwhile and waits in the check stage.
// ----------------------------------------------------------------------------
module chunk_reception_tracker #(
   parameter int MAX_IMAGES = 4,
   parameter int MAX_CHUNKS = 1024
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // tdata: image_index[2:0], chunk_index[18:3], chunk_length[34:19], zero pad
   input  logic [crt_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // tuser: req_type[1:0]
   input  logic [crt_pkg::TYPE_W-1:0]       req_tuser,
   // response channel
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // tdata: chunk_new[0], chunk_seen[1], bytes_received[25:2],
   //        chunks_received[36:26], chunks_total[47:37], image_complete[48], pad
   output logic [crt_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   // tuser: status[2:0]
   output logic [crt_pkg::STATUS_W-1:0]     rsp_tuser,
   // configuration write channel
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [crt_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [crt_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   import crt_pkg::*;

   localparam int WPI   = (MAX_CHUNKS + 31) / 32;
   localparam int DEPTH = MAX_IMAGES * WPI;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int IW    = (MAX_IMAGES > 1) ? $clog2(MAX_IMAGES) : 1;
   localparam int CW    = $clog2(MAX_CHUNKS + 1);
   localparam int OW    = (CW > CNT_W) ? CW : CNT_W;
   localparam int QW    = SIZE_W + 1;
   localparam int STEPW = $clog2(SIZE_W);

   // configuration registers
   logic [CHUNK_W-1:0]  chunk_size_ff;
   logic [ICOUNT_W-1:0] image_count_ff;
   logic [SIZE_W-1:0]   image_size_ff [NUM_SIZES];

   // per-image counters
   logic [BYTE_W-1:0]   byte_cnt_ff  [MAX_IMAGES];
   logic [CW-1:0]       chunk_cnt_ff [MAX_IMAGES];
   logic [CW-1:0]       total_ff     [MAX_IMAGES];
   logic                cmpl_ff      [MAX_IMAGES];
   logic                session_ok_ff;

   // sequencer
   crt_state_type       state_ff, state_in;
   logic [AW-1:0]       sweep_ff;
   logic                sweep_last;

   // latched request
   logic [TYPE_W-1:0]   r_type_ff;
   logic [IMG_W-1:0]    r_img_ff;
   logic [IDX_W-1:0]    r_idx_ff;
   logic [LEN_W-1:0]    r_len_ff;
   logic [31:0]         prod_ff;

   // divider
   logic [CHUNK_W-1:0]  rem_ff;
   logic [SIZE_W-1:0]   quo_ff;
   logic [STEPW-1:0]    step_ff;
   logic [IMG_W-1:0]    div_img_ff;
   logic                clr_ok_ff;
   logic [CHUNK_W:0]    div_shift;
   logic                div_ge;
   logic [QW-1:0]       div_total;
   logic                div_over;

   // response register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0]   rsp_data_ff;
   logic [STATUS_W-1:0]      rsp_user_ff;

   // RAM ports
   logic                mem_we, mem_re;
   logic [AW-1:0]       mem_wa, mem_ra;
   logic [31:0]         mem_wd, mem_rd;

   // handshakes and shared selects
   logic                req_fire, rsp_load, rsp_free;
   logic [IMG_W-1:0]    img_act;
   logic [IW-1:0]       img_low;
   logic [SIZE_W-1:0]   size_sel;
   logic [IMG_W-1:0]    req_img;
   logic [IDX_W-1:0]    req_idx;

   // check stage results
   logic [STATUS_W-1:0] ex_status;
   logic                ex_new, ex_seen, ex_cmpl, ex_update, bit_cur;
   logic [BYTE_W-1:0]   ex_bytes;
   logic [CW-1:0]       ex_cnt, ex_tot;
   logic [31:0]         remaining, expected;
   logic [OW-1:0]       cnt_wide, tot_wide;

   // --------------------------------------------------------------------------
   // handshakes
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign csr_ready  = 1'b1;
   assign req_img    = req_tdata[REQ_IMG_LSB +: IMG_W];
   assign req_idx    = req_tdata[REQ_IDX_LSB +: IDX_W];

   // images in the session, capped at the slot count
   assign img_act = (image_count_ff > IMG_W'(MAX_IMAGES)) ? IMG_W'(MAX_IMAGES)
                                                          : image_count_ff;
   assign img_low = r_img_ff[IW-1:0];

   // one image size read, shared by the divider and the length check
   assign size_sel = (state_ff == ST_DIV_LOAD) ? image_size_ff[div_img_ff[1:0]]
                                               : image_size_ff[r_img_ff[1:0]];

   assign sweep_last = (sweep_ff == AW'(DEPTH - 1));

   // --------------------------------------------------------------------------
   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_size_ff  <= '0;
         image_count_ff <= '0;
         for (int i = 0; i < NUM_SIZES; i++) begin
            image_size_ff[i] <= '0;
         end
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index) inside
            CSR_CHUNK_SIZE:  chunk_size_ff  <= csr_wdata[CHUNK_W-1:0];
            CSR_IMAGE_COUNT: image_count_ff <= csr_wdata[ICOUNT_W-1:0];
            [CSR_IMAGE_SIZE_0:CSR_IMAGE_SIZE_3]: begin
               image_size_ff[2'(csr_index - CSR_IMAGE_SIZE_0)] <= csr_wdata;
            end
            default: ;
         endcase
      end
   end

   // --------------------------------------------------------------------------
   // bitmap RAM
   crt_ram #(
      .WIDTH (32),
      .DEPTH (DEPTH)
   ) u_bitmap (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_wa),
      .wr_data (mem_wd),
      .rd_en   (mem_re),
      .rd_addr (mem_ra),
      .rd_data (mem_rd)
   );

   // --------------------------------------------------------------------------
   // divider step: restoring, one quotient bit per cycle
   assign div_shift = {rem_ff, quo_ff[SIZE_W-1]};
   assign div_ge    = (div_shift >= {1'b0, chunk_size_ff});
   assign div_total = QW'(quo_ff) + QW'(rem_ff != '0);
   assign div_over  = (div_total > QW'(MAX_CHUNKS));

   // --------------------------------------------------------------------------
   // check stage: status and counters of an arrival or query
   always_comb begin
      ex_status = STATUS_OK;
      ex_new    = 1'b0;
      ex_seen   = 1'b0;
      ex_cmpl   = 1'b0;
      ex_update = 1'b0;
      ex_bytes  = '0;
      ex_cnt    = '0;
      ex_tot    = '0;
      bit_cur   = mem_rd[r_idx_ff[4:0]];
      remaining = {{(32 - SIZE_W){1'b0}}, size_sel} - prod_ff;
      expected  = (remaining < 32'(chunk_size_ff)) ? remaining : 32'(chunk_size_ff);
      if (r_type_ff == REQ_ARRIVAL || r_type_ff == REQ_QUERY) begin
         if (!session_ok_ff) begin
            ex_status = STATUS_INVALID;
         end else if (r_img_ff >= img_act) begin
            ex_status = STATUS_BAD_IMAGE;
         end else begin
            ex_bytes = byte_cnt_ff[img_low];
            ex_cnt   = chunk_cnt_ff[img_low];
            ex_tot   = total_ff[img_low];
            ex_cmpl  = cmpl_ff[img_low];
            if (17'(r_idx_ff) >= 17'(ex_tot)) begin
               ex_status = STATUS_BAD_INDEX;
            end else if (r_type_ff == REQ_QUERY) begin
               ex_seen = bit_cur;
            end else if (r_len_ff == '0 || 32'(r_len_ff) != expected) begin
               ex_status = STATUS_BAD_LEN;
               ex_seen   = bit_cur;
            end else begin
               // good arrival; only the first one of a chunk bumps the counters
               ex_seen   = 1'b1;
               ex_update = 1'b1;
               if (!bit_cur) begin
                  ex_new   = 1'b1;
                  ex_bytes = ex_bytes + BYTE_W'(r_len_ff);
                  ex_cnt   = ex_cnt + CW'(1);
               end
               ex_cmpl = (ex_cnt == ex_tot);
            end
         end
      end
   end

   assign cnt_wide = OW'(ex_cnt);
   assign tot_wide = OW'(ex_tot);

   // --------------------------------------------------------------------------
   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT: begin
            if (sweep_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_fire) begin
               state_in = (req_tuser == REQ_CLEAR) ? ST_CLR_SWEEP : ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         ST_CLR_SWEEP: begin
            if (sweep_last) state_in = ST_DIV_LOAD;
         end
         ST_DIV_LOAD: begin
            state_in = (!clr_ok_ff || div_img_ff >= img_act) ? ST_CLR_RESP : ST_DIV_RUN;
         end
         ST_DIV_RUN: begin
            if (step_ff == STEPW'(SIZE_W - 1)) state_in = ST_DIV_CHECK;
         end
         ST_DIV_CHECK: begin
            state_in = ST_DIV_LOAD;
         end
         ST_CLR_RESP: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // --------------------------------------------------------------------------
   // sequencer outputs: RAM access and response load
   always_comb begin
      mem_we   = 1'b0;
      mem_wa   = sweep_ff;
      mem_wd   = '0;
      mem_re   = 1'b0;
      mem_ra   = AW'(32'(req_img[IW-1:0]) * 32'(WPI) + 32'(req_idx[IDX_W-1:5]));
      rsp_load = 1'b0;
      unique case (state_ff)
         ST_INIT, ST_CLR_SWEEP: begin
            mem_we = 1'b1;
         end
         ST_IDLE: begin
            mem_re = req_fire;
         end
         ST_EXEC: begin
            rsp_load = rsp_free;
            mem_we   = rsp_free && ex_new;
            mem_wa   = AW'(32'(img_low) * 32'(WPI) + 32'(r_idx_ff[IDX_W-1:5]));
            mem_wd   = mem_rd | (32'd1 << r_idx_ff[4:0]);
         end
         ST_CLR_RESP: begin
            rsp_load = rsp_free;
         end
         default: ;
      endcase
   end

   // --------------------------------------------------------------------------
   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INIT;
         sweep_ff      <= '0;
         session_ok_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (state_ff == ST_INIT || state_ff == ST_CLR_SWEEP) begin
            sweep_ff <= sweep_last ? '0 : sweep_ff + AW'(1);
         end
         if (state_ff == ST_CLR_SWEEP) begin
            session_ok_ff <= 1'b0;
         end else if (state_ff == ST_CLR_RESP && rsp_free) begin
            session_ok_ff <= clr_ok_ff;
         end
      end
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_tready);

   // request capture and offset product
   always_ff @(posedge clock) begin
      if (req_fire) begin
         r_type_ff <= req_tuser;
         r_img_ff  <= req_img;
         r_idx_ff  <= req_idx;
         r_len_ff  <= req_tdata[REQ_LEN_LSB +: LEN_W];
         prod_ff   <= 32'(req_idx) * 32'(chunk_size_ff);
      end
   end

   // per-image counters: cleared by a clear, totals set by the divider, updated by a good arrival
   always_ff @(posedge clock) begin
      if (state_ff == ST_CLR_SWEEP) begin
         for (int i = 0; i < MAX_IMAGES; i++) begin
            byte_cnt_ff[i]  <= '0;
            chunk_cnt_ff[i] <= '0;
            total_ff[i]     <= '0;
            cmpl_ff[i]      <= 1'b0;
         end
      end else if (state_ff == ST_EXEC && rsp_free && ex_update) begin
         byte_cnt_ff[img_low]  <= ex_bytes;
         chunk_cnt_ff[img_low] <= ex_cnt;
         cmpl_ff[img_low]      <= ex_cmpl;
      end else if (state_ff == ST_DIV_CHECK && !div_over) begin
         total_ff[div_img_ff[IW-1:0]] <= CW'(div_total);
      end
   end

   // chunk total divider
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_CLR_SWEEP: begin
            clr_ok_ff  <= (chunk_size_ff != '0);
            div_img_ff <= '0;
         end
         ST_DIV_LOAD: begin
            rem_ff  <= '0;
            quo_ff  <= size_sel;
            step_ff <= '0;
         end
         ST_DIV_RUN: begin
            rem_ff  <= div_ge ? CHUNK_W'(div_shift - {1'b0, chunk_size_ff})
                              : div_shift[CHUNK_W-1:0];
            quo_ff  <= {quo_ff[SIZE_W-2:0], div_ge};
            step_ff <= step_ff + STEPW'(1);
         end
         ST_DIV_CHECK: begin
            if (div_over) begin
               clr_ok_ff <= 1'b0;
            end else begin
               div_img_ff <= div_img_ff + IMG_W'(1);
            end
         end
         default: ;
      endcase
   end

   // response register
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         if (state_ff == ST_CLR_RESP) begin
            rsp_user_ff <= clr_ok_ff ? STATUS_OK : STATUS_INVALID;
            rsp_data_ff <= '0;
         end else begin
            rsp_user_ff <= ex_status;
            rsp_data_ff <= RSP_TDATA_W'({ex_cmpl, tot_wide[CNT_W-1:0], cnt_wide[CNT_W-1:0],
                                         ex_bytes, ex_seen, ex_new});
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// File: rtl/crt_checker.sv
// ----------------------------------------------------------------------------
// crt_checker
// Port-level checks of the chunk reception tracker, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module crt_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [crt_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input logic [crt_pkg::STATUS_W-1:0]     rsp_tuser
);

   import crt_pkg::*;

   // a stalled response keeps its payload
   `CRT_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "response changed while stalled")

   // requests are spaced by the read-modify-write of the bitmap
   `CRT_ASSERT(a_req_spacing, clock, reset, req_tvalid && req_tready |=> !req_tready, "request accepted in back-to-back cycles")

   // a newly recorded chunk is always reported as ok and seen
   `CRT_ASSERT(a_new_is_ok, clock, reset, rsp_tvalid && rsp_tdata[RSP_NEW_BIT] |-> rsp_tdata[RSP_SEEN_BIT] && rsp_tuser == STATUS_OK, "new chunk with bad status or clear bit")

   // reset leaves no response and starts the bitmap clearing pass
   `CRT_ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> !rsp_tvalid && !req_tready, "block active right after reset")

endmodule

bind chunk_reception_tracker crt_checker u_crt_checker (.*);

// File: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the chunk reception tracker. A behavioral copy of
// the tracker predicts every response; requests go out in random bursts while
// the response side stalls on its own pattern. Directed checks of the session
// corner cases run first, then randomized sessions of well-formed chunk
// streams mixed with broken and random requests.
// ----------------------------------------------------------------------------
module tb;
   import crt_pkg::*;

   localparam int MAX_IMAGES   = 4;
   localparam int MAX_CHUNKS   = 1024;
   localparam int RANDOM_ITEMS = 1350;

   typedef struct packed {
      logic [TYPE_W-1:0] kind;
      logic [IMG_W-1:0]  img;
      logic [IDX_W-1:0]  idx;
      logic [LEN_W-1:0]  len;
   } chunk_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                is_new;
      logic                seen;
      logic [BYTE_W-1:0]   bytes;
      logic [CNT_W-1:0]    rcvd;
      logic [CNT_W-1:0]    total;
      logic                done;
   } chunk_answer_type;

   logic                       clock;
   logic                       reset;
   logic                       req_tvalid;
   logic                       req_tready;
   logic [REQ_TDATA_W-1:0]     req_tdata;
   logic [TYPE_W-1:0]          req_tuser;
   logic                       rsp_tvalid;
   logic                       rsp_tready;
   logic [RSP_TDATA_W-1:0]     rsp_tdata;
   logic [STATUS_W-1:0]        rsp_tuser;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [CSR_INDEX_W-1:0]     csr_index;
   logic [CSR_DATA_W-1:0]      csr_wdata;

   // register shadow
   logic [CHUNK_W-1:0]         cfg_chunk_size;
   logic [ICOUNT_W-1:0]        cfg_image_count;
   logic [SIZE_W-1:0]          cfg_image_size [NUM_SIZES];

   // tracker state as the block should hold it
   logic [MAX_CHUNKS-1:0]      rx_map    [MAX_IMAGES];
   logic [BYTE_W-1:0]          rx_bytes  [MAX_IMAGES];
   logic [CNT_W-1:0]           rx_chunks [MAX_IMAGES];
   logic [CNT_W-1:0]           rx_totals [MAX_IMAGES];
   logic                       rx_done   [MAX_IMAGES];
   logic                       session_ok;

   chunk_answer_type           tracker_answers_q [$];
   int                         mismatch_count;
   int                         answers_checked;
   int                         burst_left;

   chunk_reception_tracker #(
      .MAX_IMAGES (MAX_IMAGES),
      .MAX_CHUNKS (MAX_CHUNKS)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // run limit
   initial begin
      #1_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   // ------------------------------------------------------------------------
   // prediction
   // ------------------------------------------------------------------------

   function automatic int unsigned active_images();
      return (cfg_image_count > MAX_IMAGES) ? MAX_IMAGES : cfg_image_count;
   endfunction

   function automatic void empty_images();
      int i;
      for (i = 0; i < MAX_IMAGES; i++) begin
         rx_map[i]    = '0;
         rx_bytes[i]  = '0;
         rx_chunks[i] = '0;
         rx_totals[i] = '0;
         rx_done[i]   = 1'b0;
      end
   endfunction

   // byte length a chunk must carry: full size except a short last chunk
   function automatic logic [63:0] chunk_bytes(int unsigned img, logic [IDX_W-1:0] idx);
      logic [63:0] size64;
      logic [63:0] cs64;
      logic [63:0] remaining;
      size64    = cfg_image_size[img];
      cs64      = cfg_chunk_size;
      remaining = idx;
      remaining = size64 - remaining * cs64;
      return (remaining < cs64) ? remaining : cs64;
   endfunction

   function automatic chunk_answer_type predict_tracker_answer(chunk_req_type r);
      chunk_answer_type a;
      int unsigned   n_img;
      int unsigned   i;
      logic [63:0]   size64;
      logic [63:0]   cs64;
      logic [63:0]   quot;
      logic          ok;
      logic          bit_now;
      a     = '0;
      n_img = active_images();
      if (r.kind == REQ_UNUSED)
         return a;
      // clear: empty everything and work out the chunk totals
      if (r.kind == REQ_CLEAR) begin
         empty_images();
         ok   = (cfg_chunk_size != 0);
         cs64 = cfg_chunk_size;
         for (i = 0; i < n_img && ok; i++) begin
            size64 = cfg_image_size[i];
            quot   = (size64 + cs64 - 1) / cs64;
            if (quot > MAX_CHUNKS)
               ok = 1'b0;
            else
               rx_totals[i] = quot[CNT_W-1:0];
         end
         session_ok = ok;
         a.status   = ok ? STATUS_OK : STATUS_INVALID;
         return a;
      end
      if (!session_ok) begin
         a.status = STATUS_INVALID;
         return a;
      end
      if (r.img >= n_img) begin
         a.status = STATUS_BAD_IMAGE;
         return a;
      end
      a.bytes = rx_bytes[r.img];
      a.rcvd  = rx_chunks[r.img];
      a.total = rx_totals[r.img];
      a.done  = rx_done[r.img];
      if (r.idx >= rx_totals[r.img]) begin
         a.status = STATUS_BAD_INDEX;
         return a;
      end
      bit_now = rx_map[r.img][r.idx];
      if (r.kind == REQ_QUERY) begin
         a.seen = bit_now;
         return a;
      end
      if (r.len == 0 || {48'd0, r.len} != chunk_bytes(r.img, r.idx)) begin
         a.status = STATUS_BAD_LEN;
         a.seen   = bit_now;
         return a;
      end
      // first arrival of this chunk
      if (!bit_now) begin
         rx_map[r.img][r.idx] = 1'b1;
         rx_bytes[r.img]      = rx_bytes[r.img] + r.len;
         rx_chunks[r.img]     = rx_chunks[r.img] + 1'b1;
         a.is_new             = 1'b1;
      end
      rx_done[r.img] = (rx_chunks[r.img] == rx_totals[r.img]);
      a.seen  = 1'b1;
      a.bytes = rx_bytes[r.img];
      a.rcvd  = rx_chunks[r.img];
      a.done  = rx_done[r.img];
      return a;
   endfunction

   // ------------------------------------------------------------------------
   // response checking
   // ------------------------------------------------------------------------

   task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
      $display("ERROR: response %0d, %s: got %0d, expected %0d",
               answers_checked, field, got, want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin : answer_check
      chunk_answer_type got;
      chunk_answer_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status = rsp_tuser;
         got.is_new = rsp_tdata[RSP_NEW_BIT];
         got.seen   = rsp_tdata[RSP_SEEN_BIT];
         got.bytes  = rsp_tdata[RSP_BYTES_LSB +: BYTE_W];
         got.rcvd   = rsp_tdata[RSP_RCVD_LSB +: CNT_W];
         got.total  = rsp_tdata[RSP_TOTAL_LSB +: CNT_W];
         got.done   = rsp_tdata[RSP_CMPL_BIT];
         if (tracker_answers_q.size() == 0) begin
            report_mismatch("no request pending, status", got.status, 0);
         end else begin
            want = tracker_answers_q.pop_front();
            if (got.status !== want.status) report_mismatch("status", got.status, want.status);
            if (got.is_new !== want.is_new) report_mismatch("chunk_new", got.is_new, want.is_new);
            if (got.seen !== want.seen)     report_mismatch("chunk_seen", got.seen, want.seen);
            if (got.bytes !== want.bytes)   report_mismatch("bytes_received", got.bytes, want.bytes);
            if (got.rcvd !== want.rcvd)     report_mismatch("chunks_received", got.rcvd, want.rcvd);
            if (got.total !== want.total)   report_mismatch("chunks_total", got.total, want.total);
            if (got.done !== want.done)     report_mismatch("image_complete", got.done, want.done);
         end
         answers_checked++;
      end
   end

   // response backpressure: ready runs with short stalls, some runs unbroken
   initial begin : rsp_stall
      int unsigned ready_len;
      int unsigned stall_len;
      rsp_tready <= 1'b0;
      forever begin
         ready_len = $urandom_range(1, 24);
         stall_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
         repeat (ready_len) begin
            @(posedge clock);
            rsp_tready <= 1'b1;
         end
         repeat (stall_len) begin
            @(posedge clock);
            rsp_tready <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------

   function automatic chunk_req_type mk_req(logic [TYPE_W-1:0] kind, logic [IMG_W-1:0] img,
                                            logic [IDX_W-1:0] idx, logic [LEN_W-1:0] len);
      chunk_req_type r;
      r.kind = kind;
      r.img  = img;
      r.idx  = idx;
      r.len  = len;
      return r;
   endfunction

   // one request transaction; the sender may pause after a burst
   task automatic send_item(chunk_req_type r);
      logic [REQ_TDATA_W-1:0] payload;
      int unsigned            gap;
      payload                           = '0;
      payload[REQ_IMG_LSB +: IMG_W]     = r.img;
      payload[REQ_IDX_LSB +: IDX_W]     = r.idx;
      payload[REQ_LEN_LSB +: LEN_W]     = r.len;
      req_tdata  <= payload;
      req_tuser  <= r.kind;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      tracker_answers_q.push_back(predict_tracker_answer(r));
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // register write transaction; csr_valid stays up for a following write
   task automatic write_csr(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      if (index == CSR_CHUNK_SIZE)
         cfg_chunk_size = value[CHUNK_W-1:0];
      else if (index == CSR_IMAGE_COUNT)
         cfg_image_count = value[ICOUNT_W-1:0];
      else if (index >= CSR_IMAGE_SIZE_0 && index <= CSR_IMAGE_SIZE_3)
         cfg_image_size[index - CSR_IMAGE_SIZE_0] = value[SIZE_W-1:0];
   endtask

   // full register set; unused upper data bits carry junk
   task automatic set_session(logic [CHUNK_W-1:0] cs, logic [ICOUNT_W-1:0] count,
                              logic [NUM_SIZES-1:0][SIZE_W-1:0] sizes);
      logic [CSR_DATA_W-1:0] value;
      int                    i;
      value = $urandom;
      value[CHUNK_W-1:0] = cs;
      write_csr(CSR_CHUNK_SIZE, value);
      value = $urandom;
      value[ICOUNT_W-1:0] = count;
      write_csr(CSR_IMAGE_COUNT, value);
      for (i = 0; i < NUM_SIZES; i++)
         write_csr(CSR_IMAGE_SIZE_0 + i, sizes[i]);
      csr_valid <= 1'b0;
   endtask

   // stop sending and wait for every pending response
   task automatic wait_tracker_idle();
      req_tvalid <= 1'b0;
      while (tracker_answers_q.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // mostly well-formed arrivals, then queries, broken requests and noise
   function automatic chunk_req_type make_random_item();
      chunk_req_type r;
      int unsigned   pick;
      int unsigned   n_img;
      int unsigned   img;
      int unsigned   total;
      int unsigned   k;
      logic [63:0]   want;
      r.kind = $urandom_range(0, 3);
      r.img  = $urandom;
      r.idx  = $urandom;
      r.len  = $urandom;
      n_img  = active_images();
      pick   = $urandom_range(0, 99);
      if (!session_ok || n_img == 0 || pick >= 95)
         return r;
      img   = $urandom_range(0, n_img - 1);
      total = rx_totals[img];
      r.img = img;
      if (pick < 80 && total == 0) begin
         // zero-size image: any index is out of range
         r.kind = (pick < 70) ? REQ_ARRIVAL : REQ_QUERY;
         return r;
      end
      if (pick < 70) begin
         // well-formed arrival, usually of a chunk not yet seen
         r.kind = REQ_ARRIVAL;
         r.idx  = $urandom_range(0, total - 1);
         if ($urandom_range(0, 3) != 0)
            for (k = 0; k < total && rx_map[img][r.idx]; k++)
               r.idx = (r.idx + 1) % total;
         want  = chunk_bytes(img, r.idx);
         r.len = want[LEN_W-1:0];
         return r;
      end
      if (pick < 80) begin
         r.kind = REQ_QUERY;
         r.idx  = $urandom_range(0, total);
         return r;
      end
      // broken requests
      r.kind = REQ_ARRIVAL;
      r.idx  = (total == 0) ? 0 : $urandom_range(0, total - 1);
      want   = chunk_bytes(img, r.idx);
      case ($urandom_range(0, 3))
         0: begin
            r.img = $urandom_range(n_img, 7);
         end
         1: begin
            r.idx = total + $urandom_range(0, 3);
            r.len = cfg_chunk_size;
         end
         2: begin
            r.len = $urandom_range(0, 1) ? want[LEN_W-1:0] + 1'b1 : want[LEN_W-1:0] - 1'b1;
         end
         default: begin
            r.len = '0;
         end
      endcase
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------

   // before the first clear the session is invalid
   task automatic test_invalid_session();
      send_item(mk_req(REQ_ARRIVAL, 0, 0, 1));
      send_item(mk_req(REQ_UNUSED, 0, 0, 0));
      wait_tracker_idle();
   endtask

   // zero chunk size, and a total one above the limit
   task automatic test_invalid_clears();
      set_session(0, 2, {24'd10, 24'd10, 24'd10, 24'd10});
      send_item(mk_req(REQ_CLEAR, 0, 0, 0));
      send_item(mk_req(REQ_ARRIVAL, 0, 0, 10));
      wait_tracker_idle();
      set_session(1, 1, {24'd0, 24'd0, 24'd0, 24'(MAX_CHUNKS + 1)});
      send_item(mk_req(REQ_CLEAR, 0, 0, 0));
      wait_tracker_idle();
   endtask

   // one session through every response kind of a valid session
   task automatic test_directed_session();
      // image count above the limit, short last chunk, zero size, full bitmap, one chunk
      set_session(100, 7, {24'd100, 24'(MAX_CHUNKS * 100), 24'd0, 24'd250});
      send_item(mk_req(REQ_CLEAR, 0, 0, 0));
      send_item(mk_req(REQ_ARRIVAL, 0, 2, 50));
      send_item(mk_req(REQ_ARRIVAL, 0, 2, 50));
      send_item(mk_req(REQ_ARRIVAL, 0, 0, 99));
      send_item(mk_req(REQ_ARRIVAL, 0, 0, 0));
      send_item(mk_req(REQ_QUERY, 0, 2, 0));
      send_item(mk_req(REQ_ARRIVAL, 0, 1, 100));
      send_item(mk_req(REQ_ARRIVAL, 0, 0, 100));
      send_item(mk_req(REQ_ARRIVAL, 0, 3, 50));
      send_item(mk_req(REQ_ARRIVAL, 0, 16'hFFFF, 16'hFFFF));
      send_item(mk_req(REQ_ARRIVAL, 1, 0, 0));
      send_item(mk_req(REQ_ARRIVAL, 2, MAX_CHUNKS - 1, 100));
      send_item(mk_req(REQ_ARRIVAL, 3, 0, 100));
      send_item(mk_req(REQ_ARRIVAL, 4, 0, 100));
      send_item(mk_req(REQ_QUERY, 7, 0, 0));
      send_item(mk_req(REQ_UNUSED, 7, 16'hFFFF, 16'hFFFF));
      wait_tracker_idle();
   endtask

   // largest chunk size and image sizes, then an empty session
   task automatic test_config_extremes();
      set_session(16'hFFFF, 4, {4{24'hFFFFFF}});
      send_item(mk_req(REQ_CLEAR, 0, 0, 0));
      send_item(mk_req(REQ_ARRIVAL, 3, 256, 255));
      send_item(mk_req(REQ_ARRIVAL, 0, 0, 16'hFFFF));
      wait_tracker_idle();
      set_session(1, 0, {24'd5, 24'd5, 24'd5, 24'd5});
      send_item(mk_req(REQ_CLEAR, 0, 0, 0));
      send_item(mk_req(REQ_ARRIVAL, 0, 0, 1));
      wait_tracker_idle();
   endtask

   // random sessions, each opened by a clear
   task automatic test_random_sessions();
      logic [NUM_SIZES-1:0][SIZE_W-1:0] sizes;
      logic [CHUNK_W-1:0]               cs;
      logic [ICOUNT_W-1:0]              count;
      int unsigned                      sel;
      int unsigned                      total;
      int unsigned                      n;
      int                               sent;
      int                               i;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         sel = $urandom_range(0, 19);
         if (sel == 0)
            cs = 0;
         else if (sel == 1)
            cs = 1;
         else if (sel == 2)
            cs = 16'hFFFF;
         else
            cs = $urandom_range(1, 600);
         count = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
         for (i = 0; i < NUM_SIZES; i++) begin
            if (sel == 1) begin
               sizes[i] = $urandom_range(0, MAX_CHUNKS + 1);
            end else if (sel == 2 || cs == 0) begin
               sizes[i] = $urandom;
            end else begin
               // small totals so images can complete
               total    = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 24);
               sizes[i] = (total == 0) ? 0 : (total - 1) * cs + $urandom_range(1, cs);
            end
         end
         set_session(cs, count, sizes);
         send_item(mk_req(REQ_CLEAR, $urandom, $urandom, $urandom));
         n = $urandom_range(60, 140);
         repeat (n) send_item(make_random_item());
         sent += n;
         wait_tracker_idle();
      end
   endtask

   // ------------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------------
   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= '0;
      csr_valid  <= 1'b0;
      csr_index  <= '0;
      csr_wdata  <= '0;
      cfg_chunk_size  = '0;
      cfg_image_count = '0;
      for (int i = 0; i < NUM_SIZES; i++)
         cfg_image_size[i] = '0;
      empty_images();
      session_ok      = 1'b0;
      mismatch_count  = 0;
      answers_checked = 0;
      burst_left      = $urandom_range(1, 16);
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_invalid_session();
      test_invalid_clears();
      test_directed_session();
      test_config_extremes();
      test_random_sessions();

      wait_tracker_idle();
      repeat (16) @(posedge clock);
      if (mismatch_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
